[hw/rtl/rc4kg_pkg.sv]
// ----------------------------------------------------------------------------
// RC4 keystream generator package
// Command codes, widths and the control/status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package rc4kg_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned TBL_DEPTH = 256;

	// Command codes carried by the cmd field.
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
	localparam logic [CMD_W-1:0] CMD_KEY     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_GEN     = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // a key or generate word is taken this cycle
		logic restart;  // a restart word is taken this cycle
		logic gen;      // the word in flight is a generate step
		logic step1;    // first read data is back, second read issued
		logic step2;    // second read data is back, first write, index read
		logic step3;    // second write
		logic out_load; // the result goes into the output register
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free; // output register is empty or being drained
	} stat_t;

endpackage

[hw/rtl/rc4_keystream_generator.sv]
// ----------------------------------------------------------------------------
// RC4 keystream generator
// Holds the RC4 permutation and the key-schedule and generation index pairs,
// and executes restart, key-schedule and generate words.
// ----------------------------------------------------------------------------
//
// Channel   Signals                               Direction  Meaning
// input     in_valid, in_stall, cmd, key_byte,    in         one command word
//           mask_byte
// output    out_valid, out_stall, stream_byte     out        keystream byte ^ mask
//
// After acceptance, a key or generate word issues one read of the
// permutation memory (one read port, one write port) in the accept cycle, then
// the second read, the first write together with the output-index read (generate
// words only), and the second write, in states S1, S2 and S3. The input is stalled
// until the word is through, so a new word is not taken while one is in progress.
// A restart or unused command word is taken without leaving the idle state and produces no result.
// Reset and restart clear a per-entry valid vector at once, so the memory reads
// as identity immediately; there is no clearing pass.
// A stalled output holds a generate step in S3 until the output register frees;
// the output register lets the next word be accepted while a result waits to be taken.
//
module rc4_keystream_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rc4kg_pkg::CMD_W-1:0]  cmd,
	input  logic [rc4kg_pkg::BYTE_W-1:0] key_byte,
	input  logic [rc4kg_pkg::BYTE_W-1:0] mask_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rc4kg_pkg::BYTE_W-1:0] stream_byte
);
	import rc4kg_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// Sequencer: decides when a word is taken and steps it through the memory.
	rc4kg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// Memory, indices, swap forwarding and the output register.
	rc4kg_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.key_byte    (key_byte),
		.mask_byte   (mask_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.stream_byte (stream_byte)
	);

	// A key or generate word keeps the input busy in the following cycle.
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (cmd == CMD_KEY || cmd == CMD_GEN)) |=> in_stall)
		else $error("input not busy after a key or generate word");

	// A restart leaves the input free in the following cycle.
	a_restart_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && cmd == CMD_RESTART) |=> !in_stall)
		else $error("input busy after a restart word");

	// A result appears only as the outcome of a generate word.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && cmd == CMD_GEN, 4))
		else $error("result without a generate word");

endmodule

[hw/rtl/rc4kg_ctrl.sv]
// ----------------------------------------------------------------------------
// RC4 keystream generator controller
// Sequences one key or generate step through the memory states S1, S2 and S3.
// ----------------------------------------------------------------------------
module rc4kg_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [rc4kg_pkg::CMD_W-1:0] cmd,
	output logic                      in_stall,
	input  rc4kg_pkg::stat_t          stat,
	output rc4kg_pkg::ctrl_t          ctrl
);
	import rc4kg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_S1   = 4'b0010,
		ST_S2   = 4'b0100,
		ST_S3   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   gen_q;
	logic   take;
	logic   is_step;

	assign in_stall = (state_q != ST_IDLE);
	assign take     = in_valid && (state_q == ST_IDLE);
	assign is_step  = (cmd == CMD_KEY) || (cmd == CMD_GEN);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && is_step) begin
					state_nxt = ST_S1;
				end
			end
			ST_S1: state_nxt = ST_S2;
			ST_S2: state_nxt = ST_S3;
			ST_S3: begin
				// A generate step waits here until the output register has room.
				if (!gen_q || stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gen_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (take) begin
				gen_q <= (cmd == CMD_GEN);
			end
		end
	end

	always_comb begin
		ctrl.accept   = take && is_step;
		ctrl.restart  = take && (cmd == CMD_RESTART);
		ctrl.gen      = (state_q == ST_IDLE) ? (cmd == CMD_GEN) : gen_q;
		ctrl.step1    = (state_q == ST_S1);
		ctrl.step2    = (state_q == ST_S2);
		ctrl.step3    = (state_q == ST_S3);
		ctrl.out_load = (state_q == ST_S3) && gen_q && stat.out_free;
	end

endmodule

[hw/rtl/rc4kg_dpath.sv]
// ----------------------------------------------------------------------------
// RC4 keystream generator datapath
// Permutation memory with per-entry valid bits, index registers, swap
// sequencing and the output register.
// ----------------------------------------------------------------------------
module rc4kg_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rc4kg_pkg::ctrl_t             ctrl,
	output rc4kg_pkg::stat_t             stat,
	input  logic [rc4kg_pkg::BYTE_W-1:0] key_byte,
	input  logic [rc4kg_pkg::BYTE_W-1:0] mask_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rc4kg_pkg::BYTE_W-1:0] stream_byte
);
	import rc4kg_pkg::*;

	// Permutation memory; an entry never written since restart reads as its index.
	logic [BYTE_W-1:0]    mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] vld_q;

	logic [BYTE_W-1:0] rd_q;
	logic [BYTE_W-1:0] rd_addr_q;
	logic              rd_vld_q;
	logic [BYTE_W-1:0] rd_val;
	logic [BYTE_W-1:0] raddr;
	logic              re;
	logic [BYTE_W-1:0] waddr;
	logic [BYTE_W-1:0] wdata;
	logic              we;

	logic [BYTE_W-1:0] sched_i_q, sched_j_q, gen_a_q, gen_b_q;
	logic [BYTE_W-1:0] x_q, y_q, sa_q, sb_q, idx_q;
	logic [BYTE_W-1:0] key_q, mask_q;
	logic [BYTE_W-1:0] y_nxt, idx_nxt, x_nxt, fwd;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_q;

	assign rd_val  = rd_vld_q ? rd_q : rd_addr_q;
	assign x_nxt   = ctrl.gen ? (gen_a_q + 8'd1) : sched_i_q;
	assign y_nxt   = ctrl.gen ? (gen_b_q + rd_val) : (sched_j_q + rd_val + key_q);
	assign idx_nxt = sa_q + rd_val;

	always_comb begin
		priority if (ctrl.accept) begin
			raddr = x_nxt;
		end else if (ctrl.step1) begin
			raddr = y_nxt;
		end else begin
			raddr = idx_nxt;
		end
	end
	assign re = ctrl.accept || ctrl.step1 || (ctrl.step2 && ctrl.gen);

	assign we    = ctrl.step2 || ctrl.step3;
	assign waddr = ctrl.step2 ? x_q : y_q;
	assign wdata = ctrl.step2 ? rd_val : sa_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			if (ctrl.restart) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q  <= vld_q[raddr];
				rd_addr_q <= raddr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_i_q <= '0;
			sched_j_q <= '0;
			gen_a_q   <= '0;
			gen_b_q   <= '0;
		end else if (ctrl.restart) begin
			sched_i_q <= '0;
			sched_j_q <= '0;
			gen_a_q   <= '0;
			gen_b_q   <= '0;
		end else begin
			if (ctrl.accept) begin
				if (ctrl.gen) begin
					gen_a_q <= x_nxt;
				end else begin
					sched_i_q <= sched_i_q + 8'd1;
				end
			end
			if (ctrl.step1) begin
				if (ctrl.gen) begin
					gen_b_q <= y_nxt;
				end else begin
					sched_j_q <= y_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			x_q    <= x_nxt;
			key_q  <= key_byte;
			mask_q <= mask_byte;
		end
		if (ctrl.step1) begin
			y_q  <= y_nxt;
			sa_q <= rd_val;
		end
		if (ctrl.step2) begin
			sb_q  <= rd_val;
			idx_q <= idx_nxt;
		end
	end

	// The index read ran alongside the first write and before the second, so
	// the swapped values are forwarded; the later write wins.
	always_comb begin
		priority if (idx_q == y_q) begin
			fwd = sa_q;
		end else if (idx_q == x_q) begin
			fwd = sb_q;
		end else begin
			fwd = rd_val;
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_q <= fwd ^ mask_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign stream_byte = out_q;

endmodule
